FILE: rtl/sale_pkg.sv
// shared constants, codes and types of the array list engine
package sale_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int VALUE_W_DEF = 32;

  localparam int KIND_W = 3;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;
  localparam int FIDX_W = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;
  localparam logic [FIDX_W-1:0] NOT_FOUND = 5'h1f;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SORT      = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_WRITE,
    OP_SORT_EVEN,
    OP_SORT_ODD
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic             asc;
  } cell_ctl_t;

endpackage

FILE: rtl/sequential_array_list_engine_top.sv
// array list engine top level: control sequencer over a chain of list cells
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser kind, tdata position/item_value/ascending
//  m_*       out  m_tvalid/m_tready  tdata ok/found_index/read_value/list_length
//  cfg_*     in   cfg_we             cfg_wdata capacity
//
//  every operation: accepted in ST_IDLE, run in ST_EXEC, result registered in ST_FIN; next accept back in ST_IDLE
//  sort on two or more entries adds one odd-even exchange phase of the cell chain per entry
//  one operation at a time; a new one is taken while the last result waits on m_tready
//  a result still held at the end of the next operation stalls it until m_tready
//  rst is synchronous: list empty, capacity 10, no result pending
module sequential_array_list_engine_top
  import sale_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // position, item_value, ascending, zero pad
  input  logic [((POS_W+VALUE_WIDTH+1+7)/8)*8-1:0]      s_tdata,
  // kind
  input  logic [KIND_W-1:0]                             s_tuser,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // ok, found_index, read_value, list_length, zero pad
  output logic [((1+FIDX_W+VALUE_WIDTH+CNT_W+7)/8)*8-1:0] m_tdata,
  input  logic                                          cfg_we,
  input  logic [CAP_W-1:0]                              cfg_wdata
);

  localparam int OUT_DATA_W = ((1 + FIDX_W + VALUE_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int CAP_LIM    = (DEPTH > 31) ? 31 : DEPTH;
  localparam int MATCH_N    = CAP_LIM;
  localparam int RD_N       = (DEPTH > 16) ? 16 : DEPTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [KIND_W-1:0]      kind_q;
  logic [POS_W-1:0]       pos_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   asc_q;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [CAP_W-1:0]       capacity;
  logic [CNT_W-1:0]       phase_cnt;
  logic [MATCH_N-1:0]     match_q;
  logic [MATCH_N-1:0]     match_next;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [VALUE_WIDTH-1:0] rd_next;
  logic                   ok_q;
  logic                   ok_next;

  logic [CNT_W-1:0]       cap_eff;
  logic [CNT_W-1:0]       pos_ext;
  logic                   room;
  logic                   pos_ok;
  logic                   ins_ok;
  logic                   out_free;
  logic [FIDX_W-1:0]      found;
  logic                   fin_ok;
  cell_ctl_t              ctl;

  logic [VALUE_WIDTH-1:0] vals  [DEPTH];
  logic                   swaps [DEPTH];

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign cap_eff = (capacity > CAP_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : capacity;
  assign pos_ext = {1'b0, pos_q};
  assign room    = count < cap_eff;
  assign pos_ok  = pos_ext < count;
  assign ins_ok  = room && (pos_ext <= count);

  // command broadcast to the cells
  always_comb begin
    ctl.op    = OP_NONE;
    ctl.pos   = (kind_q == KIND_APPEND) ? count : pos_ext;
    ctl.count = count;
    ctl.asc   = asc_q;
    if (state == ST_EXEC) begin
      case (kind_q)
        KIND_INSERT:    ctl.op = ins_ok ? OP_INSERT : OP_NONE;
        KIND_APPEND:    ctl.op = room ? OP_INSERT : OP_NONE;
        KIND_REMOVE:    ctl.op = pos_ok ? OP_REMOVE : OP_NONE;
        KIND_OVERWRITE: ctl.op = pos_ok ? OP_WRITE : OP_NONE;
        default:        ctl.op = OP_NONE;
      endcase
    end else if (state == ST_SORT) begin
      ctl.op = phase_cnt[0] ? OP_SORT_ODD : OP_SORT_EVEN;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;
    logic                   left_s;
    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_v = vals[i-1];
      assign left_s = swaps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = vals[i+1];
    end
    sale_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_value   (val_q),
      .left_value (left_v),
      .right_value(right_v),
      .left_swap  (left_s),
      .swap       (swaps[i]),
      .value      (vals[i])
    );
  end

  // read mux, match vector, status
  always_comb begin
    rd_next = '0;
    if ((kind_q == KIND_READ) && pos_ok) begin
      for (int i = 0; i < RD_N; i++) begin
        if (pos_q == POS_W'(i)) begin
          rd_next = vals[i];
        end
      end
    end
    for (int i = 0; i < MATCH_N; i++) begin
      match_next[i] = (kind_q == KIND_FIND) && (vals[i] == val_q) && (CNT_W'(i) < count);
    end
    case (kind_q) inside
      KIND_INSERT:                ok_next = ins_ok;
      KIND_APPEND:                ok_next = room;
      KIND_REMOVE, KIND_OVERWRITE,
      KIND_READ:                  ok_next = pos_ok;
      KIND_SORT:                  ok_next = 1'b1;
      default:                    ok_next = 1'b0;
    endcase
    count_next = count;
    if (ctl.op == OP_INSERT) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.op == OP_REMOVE) begin
      count_next = count - CNT_W'(1);
    end
  end

  // first match, lowest index wins
  always_comb begin
    found = NOT_FOUND;
    for (int i = MATCH_N - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        found = FIDX_W'(i);
      end
    end
    fin_ok = (kind_q == KIND_FIND) ? |match_q : ok_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((kind_q == KIND_SORT) && (count > CNT_W'(1))) begin
          state_next = ST_SORT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SORT: begin
        if (phase_cnt == count - CNT_W'(1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      phase_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (state == ST_EXEC) begin
        count <= count_next;
      end
      if (state == ST_SORT) begin
        phase_cnt <= phase_cnt + CNT_W'(1);
      end else begin
        phase_cnt <= '0;
      end
      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // transaction payload and working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind_q <= s_tuser;
      pos_q  <= s_tdata[POS_W-1:0];
      val_q  <= s_tdata[POS_W +: VALUE_WIDTH];
      asc_q  <= s_tdata[POS_W+VALUE_WIDTH];
    end
    if (state == ST_EXEC) begin
      match_q <= match_next;
      rd_q    <= rd_next;
      ok_q    <= ok_next;
    end
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= OUT_DATA_W'({count, rd_q, found, fin_ok});
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_EXEC)
    else $error("accepted transaction did not start execution");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    state != ST_EXEC |=> $stable(count))
    else $error("list length changed outside execution");

  a_count_depth: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("list length beyond store depth");

  a_match_find: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && kind_q != KIND_FIND |-> match_q == '0)
    else $error("match vector set for a non-find operation");

endmodule

FILE: rtl/sale_cell.sv
// one list cell: holds an entry and trades it with its neighbors
module sale_cell
  import sale_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   left_swap,
  output logic                   swap,
  output logic [VALUE_WIDTH-1:0] value
);

  logic is_sort;
  logic odd_phase;
  logic pair_right;
  logic out_of_order;

  assign is_sort    = (ctl.op == OP_SORT_EVEN) || (ctl.op == OP_SORT_ODD);
  assign odd_phase  = (ctl.op == OP_SORT_ODD);
  assign pair_right = is_sort && (((IDX % 2) == 1) == odd_phase)
                      && ((IDX + 1) < int'(ctl.count));

  always_comb begin
    if (ctl.asc) begin
      out_of_order = $signed(value) > $signed(right_value);
    end else begin
      out_of_order = $signed(value) < $signed(right_value);
    end
  end

  assign swap = pair_right && out_of_order;

  always_ff @(posedge clk) begin
    case (ctl.op) inside
      OP_INSERT: begin
        if (IDX == int'(ctl.pos)) begin
          value <= wr_value;
        end else if ((IDX > int'(ctl.pos)) && (IDX <= int'(ctl.count))) begin
          value <= left_value;
        end
      end
      OP_REMOVE: begin
        if ((IDX >= int'(ctl.pos)) && ((IDX + 1) < int'(ctl.count))) begin
          value <= right_value;
        end
      end
      OP_WRITE: begin
        if (IDX == int'(ctl.pos)) begin
          value <= wr_value;
        end
      end
      OP_SORT_EVEN, OP_SORT_ODD: begin
        if (swap) begin
          value <= right_value;
        end else if (left_swap) begin
          value <= left_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sim/tb_top.sv
// testbench of the array list engine: directed table then random operations checked by a predictor
`timescale 1ns / 100ps

module tb_top;
  import sale_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int LIST_DEPTH = 16;

  typedef struct packed {
    logic        ok;
    logic [4:0]  found;
    logic [31:0] rd;
    logic [4:0]  len;
  } list_result_t;

  typedef struct {
    logic [2:0]   kind;
    logic [3:0]   pos;
    logic [31:0]  val;
    logic         asc;
    bit           typed;
    list_result_t res;
  } op_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;

  sequential_array_list_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [31:0] list_mem [LIST_DEPTH];
  int                 list_count;
  int                 list_cap;

  list_result_t expected_q[$];
  op_row_t      table_rows[$];
  int           errors;
  bit           quiet_s;
  bit           quiet_m;
  list_result_t got;
  list_result_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic list_result_t apply_op(logic [2:0] kind, logic [3:0] pos,
                                            logic signed [31:0] val, logic asc);
    list_result_t r;
    logic signed [31:0] t;
    int cap;
    cap = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
    r.ok = 1'b0;
    r.found = NOT_FOUND;
    r.rd = '0;
    case (kind)
      KIND_INSERT: begin
        if (list_count < cap && int'(pos) <= list_count) begin
          for (int i = list_count; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_count++;
          r.ok = 1'b1;
        end
      end
      KIND_APPEND: begin
        if (list_count < cap) begin
          list_mem[list_count] = val;
          list_count++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (int'(pos) < list_count) begin
          for (int i = int'(pos); i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      KIND_OVERWRITE: begin
        if (int'(pos) < list_count) begin
          list_mem[pos] = val;
          r.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        for (int i = list_count - 1; i >= 0; i--) begin
          if (list_mem[i] == val) begin
            r.found = i[4:0];
            r.ok = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (int'(pos) < list_count) begin
          r.rd = list_mem[pos];
          r.ok = 1'b1;
        end
      end
      KIND_SORT: begin
        for (int i = 0; i < list_count; i++) begin
          for (int j = 0; j + 1 < list_count - i; j++) begin
            if (asc ? (list_mem[j] > list_mem[j+1]) : (list_mem[j] < list_mem[j+1])) begin
              t = list_mem[j];
              list_mem[j] = list_mem[j+1];
              list_mem[j+1] = t;
            end
          end
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.len = list_count[4:0];
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(logic [2:0] kind, logic [3:0] pos, logic [31:0] val, logic asc,
                         bit typed, list_result_t res);
    op_row_t row;
    row.kind = kind;
    row.pos = pos;
    row.val = val;
    row.asc = asc;
    row.typed = typed;
    row.res = res;
    table_rows.push_back(row);
  endtask

  task automatic send_op(logic [2:0] kind, logic [3:0] pos, logic [31:0] val, logic asc,
                         bit typed, list_result_t res);
    int gap;
    list_result_t pred;
    gap = pick_gap(quiet_s);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {3'b000, asc, val, pos};
    do @(posedge clk); while (!s_tready);
    pred = apply_op(kind, pos, val, asc);
    expected_q.push_back(typed ? res : pred);
  endtask

  task automatic write_capacity(logic [4:0] value);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    list_cap = int'(value);
  endtask

  task automatic random_op(bit grow);
    logic [2:0] k;
    logic [3:0] p;
    logic [31:0] v;
    int r;
    int hi;
    r = $urandom_range(0, 99);
    if (grow) begin
      k = r < 30 ? KIND_INSERT : r < 50 ? KIND_APPEND : r < 58 ? KIND_REMOVE :
          r < 68 ? KIND_OVERWRITE : r < 80 ? KIND_FIND : r < 92 ? KIND_READ :
          r < 97 ? KIND_SORT : KIND_UNUSED;
    end else begin
      k = r < 10 ? KIND_INSERT : r < 15 ? KIND_APPEND : r < 50 ? KIND_REMOVE :
          r < 62 ? KIND_OVERWRITE : r < 75 ? KIND_FIND : r < 90 ? KIND_READ :
          r < 97 ? KIND_SORT : KIND_UNUSED;
    end
    hi = (k == KIND_INSERT) ? list_count : list_count - 1;
    if (hi < 0) hi = 0;
    if (hi > 15) hi = 15;
    if ($urandom_range(0, 9) < 8) p = 4'($urandom_range(0, hi));
    else p = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 40 && list_count > 0) v = list_mem[$urandom_range(0, list_count - 1)];
    else if (r < 60) v = $urandom_range(0, 7) - 4;
    else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end else v = $urandom;
    send_op(k, p, v, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[5:1], m_tdata[37:6], m_tdata[42:38]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok expected %0d got %0d", $time, want.ok, got.ok);
          errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found_index expected %0h got %0h", $time, want.found, got.found);
          errors++;
        end
        if (got.rd !== want.rd) begin
          $display("%0t: read_value expected %0h got %0h", $time, want.rd, got.rd);
          errors++;
        end
        if (got.len !== want.len) begin
          $display("%0t: list_length expected %0d got %0d", $time, want.len, got.len);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    m_tready = 1'b0;
    forever begin
      int n;
      n = pick_gap(quiet_m);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    logic [4:0] caps [7];
    int left;
    bit grow;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    quiet_s = 1'b0;
    quiet_m = 1'b0;
    list_count = 0;
    list_cap = 10;
    for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd10, 5'd17, 5'd2};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list after reset
    add_row(KIND_READ, 4'd0, 32'd0, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_REMOVE, 4'd0, 32'd0, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_OVERWRITE, 4'd0, 32'd9, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_FIND, 4'd0, 32'd0, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_SORT, 4'd0, 32'd0, 1'b1, 1'b1, '{1'b1, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_INSERT, 4'd1, 32'd5, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    add_row(KIND_UNUSED, 4'd0, 32'd5, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd0});
    // value extremes
    add_row(KIND_APPEND, 4'd0, 32'h7fff_ffff, 1'b0, 1'b1, '{1'b1, NOT_FOUND, 32'd0, 5'd1});
    add_row(KIND_INSERT, 4'd0, 32'h8000_0000, 1'b0, 1'b1, '{1'b1, NOT_FOUND, 32'd0, 5'd2});
    add_row(KIND_READ, 4'd0, 32'd0, 1'b0, 1'b1, '{1'b1, NOT_FOUND, 32'h8000_0000, 5'd2});
    add_row(KIND_READ, 4'd1, 32'd0, 1'b0, 1'b1, '{1'b1, NOT_FOUND, 32'h7fff_ffff, 5'd2});
    add_row(KIND_FIND, 4'd0, 32'h8000_0000, 1'b0, 1'b1, '{1'b1, 5'd0, 32'd0, 5'd2});
    add_row(KIND_INSERT, 4'd2, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_INSERT, 4'd1, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(KIND_OVERWRITE, 4'd3, 32'd1, 1'b0, 1'b0, '0);
    add_row(KIND_OVERWRITE, 4'd15, 32'd1, 1'b0, 1'b1, '{1'b0, NOT_FOUND, 32'd0, 5'd4});
    add_row(KIND_SORT, 4'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_READ, 4'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_READ, 4'd3, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_SORT, 4'd15, 32'd0, 1'b1, 1'b0, '0);
    add_row(KIND_READ, 4'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_FIND, 4'd0, 32'd1234, 1'b0, 1'b0, '0);
    add_row(KIND_REMOVE, 4'd0, 32'd0, 1'b0, 1'b0, '0);
    add_row(KIND_REMOVE, 4'd15, 32'd0, 1'b0, 1'b0, '0);
    foreach (table_rows[i])
      send_op(table_rows[i].kind, table_rows[i].pos, table_rows[i].val, table_rows[i].asc,
              table_rows[i].typed, table_rows[i].res);

    for (int ph = 0; ph < 12; ph++) begin
      write_capacity(ph < 7 ? caps[ph] : 5'($urandom_range(0, 31)));
      quiet_s = (ph % 4 == 3);
      quiet_m = (ph % 4 == 3);
      grow = 1'b1;
      left = $urandom_range(20, 80);
      for (int n = 0; n < 150; n++) begin
        if (left == 0) begin
          grow = ~grow;
          left = $urandom_range(20, 80);
        end
        left--;
        random_op(grow);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
